// File: src/isort_pkg.sv
`default_nettype none
package isort_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the broadcast value
        logic shift;  // move every entry one place towards cell 0
    } isort_ctrl_t;

    // Status that one cell hands to its neighbours.
    typedef struct packed {
        logic valid;  // cell holds an entry
        logic gt;     // entry is strictly greater than the broadcast value
    } isort_link_t;

endpackage
`default_nettype wire

// File: src/isort_cell.sv
`default_nettype none
module isort_cell #(
    parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire isort_pkg::isort_ctrl_t  ctrl,
    input  wire logic [DATA_WIDTH-1:0]   ins_value,
    input  wire isort_pkg::isort_link_t  prev_link,
    input  wire logic [DATA_WIDTH-1:0]   prev_value,
    input  wire isort_pkg::isort_link_t  next_link,
    input  wire logic [DATA_WIDTH-1:0]   next_value,
    output isort_pkg::isort_link_t       link,
    output logic [DATA_WIDTH-1:0]        value
);
    import isort_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  gt;

    assign gt = valid_reg && ($signed(value_reg) > $signed(ins_value));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift) begin
            valid_next = next_link.valid;
            value_next = next_value;
        end else if (ctrl.ins) begin
            // Entries greater than the new value move up one place; the new
            // value lands in the first greater cell or the first free one.
            if (prev_link.gt) begin
                valid_next = 1'b1;
                value_next = prev_value;
            end else if (gt || (!valid_reg && prev_link.valid)) begin
                valid_next = 1'b1;
                value_next = ins_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign value      = value_reg;

endmodule
`default_nettype wire

// File: src/insertion_sorter_core.sv
`default_nettype none
// Batch insertion sorter. Signed values arrive one per item and are inserted
// into a row of DEPTH cells that keeps them in ascending order, equal values
// in arrival order. While a batch is loading, one item is accepted every
// cycle. The item with tlast ends the batch: the chain then shifts its N
// entries out through cell 0, one result per cycle when the output side is
// ready, and no item is accepted until the last result has entered the
// output register. The result marked tlast ends the batch. Values that
// arrive while all cells are full are dropped and tuser is set on every
// result of that batch.
module insertion_sorter_core #(
    parameter int DEPTH      = isort_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // value
    input  wire                       s_tlast,   // batch_end
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [TDATA_W-1:0]        m_tdata,   // sorted_value
    output logic                      m_tlast,   // final_res
    output logic                      m_tuser    // overflow
);
    import isort_pkg::*;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [DATA_WIDTH-1:0] m_data_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    isort_ctrl_t           ctrl;
    isort_link_t           link      [DEPTH];
    logic [DATA_WIDTH-1:0] cell_value[DEPTH];
    logic [DEPTH-1:0]      valid_vec;
    logic [DATA_WIDTH-1:0] in_value;
    logic                  accept;
    logic                  full;
    logic                  pop;
    logic                  pop_last;

    assign in_value  = s_tdata[DATA_WIDTH-1:0];
    assign s_tready  = (state_reg == ST_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign full      = valid_vec[DEPTH-1];
    assign pop       = (state_reg == ST_DRAIN) && (!m_valid_reg || m_tready);
    assign pop_last  = pop && !valid_vec[1];
    assign ctrl.ins   = accept && !full;
    assign ctrl.shift = pop;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            isort_link_t           prev_link;
            isort_link_t           next_link;
            logic [DATA_WIDTH-1:0] prev_value;
            logic [DATA_WIDTH-1:0] next_value;

            if (i == 0) begin : g_first
                assign prev_link.valid = 1'b1;
                assign prev_link.gt    = 1'b0;
                assign prev_value      = '0;
            end else begin : g_mid_prev
                assign prev_link  = link[i-1];
                assign prev_value = cell_value[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign next_link.valid = 1'b0;
                assign next_link.gt    = 1'b0;
                assign next_value      = '0;
            end else begin : g_mid_next
                assign next_link  = link[i+1];
                assign next_value = cell_value[i+1];
            end

            isort_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .ins_value  (in_value),
                .prev_link  (prev_link),
                .prev_value (prev_value),
                .next_link  (next_link),
                .next_value (next_value),
                .link       (link[i]),
                .value      (cell_value[i])
            );

            assign valid_vec[i] = link[i].valid;
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (pop) begin
                    m_valid_next = 1'b1;
                    if (pop_last) begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= cell_value[0];
            m_last_reg <= !valid_vec[1];
            m_user_reg <= dropped_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Occupied cells always form an unbroken run starting at cell 0.
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + DEPTH'(1))) == '0))
        else $error("occupied cells are not contiguous");

    // A batch being drained is never empty.
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> valid_vec[0])
        else $error("drain with empty chain");

    // The item that ends a batch starts the drain.
    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (state_reg == ST_DRAIN))
        else $error("batch end did not start drain");

    // Emitting the final result empties the chain and clears the drop flag.
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_last |=> (state_reg == ST_LOAD) && (valid_vec == '0) && !dropped_reg)
        else $error("chain not cleared after final result");

endmodule
`default_nettype wire
